// File: rtl/ipv4p_pkg.sv
// package: shared state type and character / phase / radix codes of the ipv4 text parser
`timescale 1ns / 1ps

package ipv4p_pkg;

    // parse phase codes
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_ZERO   = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_FAIL   = 3'd4;

    // radix codes
    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_HEX = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    // part range limits
    localparam logic [31:0] LIM_24 = 32'h00ff_ffff;
    localparam logic [31:0] LIM_16 = 32'h0000_ffff;
    localparam logic [31:0] LIM_8  = 32'h0000_00ff;

    // parser state
    typedef struct packed {
        logic [2:0]       phase;
        logic [1:0]       radix;
        logic [31:0]      accum;
        logic [2:0][31:0] saved;
        logic [1:0]       part_count;
    } state_t;

    // state after reset and after each end of string
    localparam state_t STATE_RESET = '{
        phase:      PH_START,
        radix:      RX_DEC,
        accum:      32'd0,
        saved:      '0,
        part_count: 2'd0
    };

endpackage

// File: rtl/ipv4p_step.sv
// module: next-state and result logic for one character of the address text
`timescale 1ns / 1ps

module ipv4p_step
(
    input  ipv4p_pkg::state_t cur,
    input  logic [7:0]        char_code,
    output ipv4p_pkg::state_t nxt,
    output logic              res_valid,
    output logic              res_ok,
    output logic [31:0]       res_addr
);

    logic        is_dec;
    logic        is_space;
    logic        is_hex_lo;
    logic        is_hex_up;
    logic        is_x;
    logic [3:0]  dig;
    logic [3:0]  hex_letter;
    logic [1:0]  eff_radix;
    logic [31:0] acc_dec;
    logic [31:0] acc_oct;
    logic [31:0] acc_hex_d;
    logic [31:0] acc_hex_l;
    logic        fin_ok;
    logic [31:0] fin_addr;

    // character classes
    assign is_dec    = (char_code >= ipv4p_pkg::CH_ZERO) && (char_code <= ipv4p_pkg::CH_NINE);
    assign is_space  = (char_code == ipv4p_pkg::CH_SPACE) ||
                       ((char_code >= ipv4p_pkg::CH_TAB) && (char_code <= ipv4p_pkg::CH_CR));
    assign is_hex_lo = (char_code >= ipv4p_pkg::CH_A_LO) && (char_code <= ipv4p_pkg::CH_F_LO);
    assign is_hex_up = (char_code >= ipv4p_pkg::CH_A_UP) && (char_code <= ipv4p_pkg::CH_F_UP);
    assign is_x      = (char_code == ipv4p_pkg::CH_X_LO) || (char_code == ipv4p_pkg::CH_X_UP);

    // digit weights: letters a..f have low nibble 1..6
    assign dig        = char_code[3:0];
    assign hex_letter = char_code[3:0] + 4'd9;

    // radix in force for a digit character; a leading zero means octal
    assign eff_radix = (cur.phase == ipv4p_pkg::PH_ZERO) ? ipv4p_pkg::RX_OCT : cur.radix;

    // accumulate candidates, all modulo 2^32
    assign acc_dec   = {cur.accum[28:0], 3'b000} + {cur.accum[30:0], 1'b0} + {28'd0, dig};
    assign acc_oct   = {cur.accum[28:0], 3'b000} + {28'd0, dig};
    assign acc_hex_d = {cur.accum[27:0], dig};
    assign acc_hex_l = {cur.accum[27:0], hex_letter};

    // packing and range checks over the saved parts
    always_comb
    begin
        fin_ok   = 1'b1;
        fin_addr = cur.accum;
        case (cur.part_count)
            2'd0:
            begin
                fin_ok = 1'b1;
            end
            2'd1:
            begin
                fin_ok   = (cur.accum <= ipv4p_pkg::LIM_24) && (cur.saved[0] <= ipv4p_pkg::LIM_8);
                fin_addr = cur.accum | {cur.saved[0][7:0], 24'd0};
            end
            2'd2:
            begin
                fin_ok   = (cur.accum <= ipv4p_pkg::LIM_16) &&
                           (cur.saved[0] <= ipv4p_pkg::LIM_8) &&
                           (cur.saved[1] <= ipv4p_pkg::LIM_8);
                fin_addr = cur.accum | {cur.saved[0][7:0], cur.saved[1][7:0], 16'd0};
            end
            default:
            begin
                fin_ok   = (cur.accum <= ipv4p_pkg::LIM_8) &&
                           (cur.saved[0] <= ipv4p_pkg::LIM_8) &&
                           (cur.saved[1] <= ipv4p_pkg::LIM_8) &&
                           (cur.saved[2] <= ipv4p_pkg::LIM_8);
                fin_addr = cur.accum |
                           {cur.saved[0][7:0], cur.saved[1][7:0], cur.saved[2][7:0], 8'd0};
            end
        endcase
    end

    // per-character transition
    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res_ok    = 1'b0;
        res_addr  = 32'd0;

        if (char_code == ipv4p_pkg::CH_NUL)
        begin
            // end of string: emit the word and return to reset state
            res_valid = 1'b1;
            if ((cur.phase == ipv4p_pkg::PH_ZERO) || (cur.phase == ipv4p_pkg::PH_DIGITS))
            begin
                res_ok   = fin_ok;
                res_addr = fin_ok ? fin_addr : 32'd0;
            end
            else if (cur.phase == ipv4p_pkg::PH_DONE)
            begin
                res_ok   = 1'b1;
                res_addr = cur.accum;
            end
            nxt = ipv4p_pkg::STATE_RESET;
        end
        else
        begin
            unique case (cur.phase) inside
                ipv4p_pkg::PH_START:
                begin
                    nxt.radix = ipv4p_pkg::RX_DEC;
                    if (!is_dec)
                    begin
                        nxt.phase = ipv4p_pkg::PH_FAIL;
                    end
                    else if (char_code == ipv4p_pkg::CH_ZERO)
                    begin
                        nxt.accum = 32'd0;
                        nxt.phase = ipv4p_pkg::PH_ZERO;
                    end
                    else
                    begin
                        nxt.accum = {28'd0, dig};
                        nxt.phase = ipv4p_pkg::PH_DIGITS;
                    end
                end
                ipv4p_pkg::PH_ZERO,
                ipv4p_pkg::PH_DIGITS:
                begin
                    if ((cur.phase == ipv4p_pkg::PH_ZERO) && is_x)
                    begin
                        nxt.radix = ipv4p_pkg::RX_HEX;
                        nxt.phase = ipv4p_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        nxt.radix = eff_radix;
                        if (is_dec)
                        begin
                            nxt.phase = ipv4p_pkg::PH_DIGITS;
                            if (eff_radix == ipv4p_pkg::RX_HEX)
                                nxt.accum = acc_hex_d;
                            else if (eff_radix == ipv4p_pkg::RX_OCT)
                                nxt.accum = acc_oct;
                            else
                                nxt.accum = acc_dec;
                        end
                        else if ((eff_radix == ipv4p_pkg::RX_HEX) && (is_hex_lo || is_hex_up))
                        begin
                            nxt.phase = ipv4p_pkg::PH_DIGITS;
                            nxt.accum = acc_hex_l;
                        end
                        else if (char_code == ipv4p_pkg::CH_DOT)
                        begin
                            // close the part, fourth dot fails
                            if (cur.part_count == 2'd3)
                            begin
                                nxt.phase = ipv4p_pkg::PH_FAIL;
                            end
                            else
                            begin
                                case (cur.part_count)
                                    2'd0:    nxt.saved[0] = cur.accum;
                                    2'd1:    nxt.saved[1] = cur.accum;
                                    default: nxt.saved[2] = cur.accum;
                                endcase
                                nxt.part_count = cur.part_count + 2'd1;
                                nxt.accum      = 32'd0;
                                nxt.radix      = ipv4p_pkg::RX_DEC;
                                nxt.phase      = ipv4p_pkg::PH_START;
                            end
                        end
                        else if (is_space)
                        begin
                            // parsing ends: pack now, ignore the rest
                            if (fin_ok)
                            begin
                                nxt.accum = fin_addr;
                                nxt.phase = ipv4p_pkg::PH_DONE;
                            end
                            else
                            begin
                                nxt.phase = ipv4p_pkg::PH_FAIL;
                            end
                        end
                        else
                        begin
                            nxt.phase = ipv4p_pkg::PH_FAIL;
                        end
                    end
                end
                ipv4p_pkg::PH_DONE:
                begin
                    nxt = cur;
                end
                default:
                begin
                    nxt.phase = ipv4p_pkg::PH_FAIL;
                end
            endcase
        end
    end

endmodule

// File: rtl/dotted_ipv4_text_parser_core.sv
// top level: streaming dotted ipv4 text parser with input and result registers
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_ready / char_code) takes one character of an
//   address text per word. Code 0 ends the string. Characters other than 0
//   produce no result; they only advance the parser state.
//   Output channel (out_valid / out_ready / addr_valid / address) delivers one
//   word per string: addr_valid high with the address (with two or more parts,
//   first part in bits 31..24), or addr_valid low with address zero when the
//   text did not parse. Result path: the terminating 0 is accepted into the
//   input register, whose step logic loads the result register once that
//   register is free. Throughput: one character per cycle while no terminating
//   0 waits on a full result register; the state update is a single shift-add
//   and compare stage between the input and result registers.
//   Stall: while a result waits and out_ready is low, characters that make no
//   result still flow; a terminating 0 holds in the input register until the
//   result register frees up, and in_ready drops behind it.
//   Reset: rst_n clears both registers and returns the parser to the start
//   of a new string.

module dotted_ipv4_text_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        addr_valid,
    output logic [31:0] address
);

    logic              in_vld_reg;
    logic [7:0]        char_reg;
    ipv4p_pkg::state_t state_reg;
    ipv4p_pkg::state_t state_next;
    logic              out_vld_reg;
    logic              addr_valid_reg;
    logic [31:0]       address_reg;
    logic              res_valid;
    logic              res_ok;
    logic [31:0]       res_addr;
    logic              out_free;
    logic              step_fire;

    // handshake control
    assign out_free  = !out_vld_reg || out_ready;
    assign step_fire = in_vld_reg && (!res_valid || out_free);
    assign in_ready  = !in_vld_reg || step_fire;

    // per-character step logic
    ipv4p_step u_step
    (
        .cur       (state_reg),
        .char_code (char_reg),
        .nxt       (state_next),
        .res_valid (res_valid),
        .res_ok    (res_ok),
        .res_addr  (res_addr)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_code;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipv4p_pkg::STATE_RESET;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step_fire && res_valid)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && res_valid)
        begin
            addr_valid_reg <= res_ok;
            address_reg    <= res_addr;
        end
    end

    assign out_valid  = out_vld_reg;
    assign addr_valid = addr_valid_reg;
    assign address    = address_reg;

`ifndef SYNTHESIS
    // a terminating character always lands a result word
    a_nul_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && res_valid |=> out_vld_reg)
        else $error("end of string did not produce a result word");

    // a failed parse reports a zero address
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !addr_valid_reg |-> address_reg == 32'd0)
        else $error("invalid result carries a nonzero address");

    // parser state is back to start after the end of a string
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && res_valid |=>
            state_reg.phase == ipv4p_pkg::PH_START && state_reg.part_count == 2'd0 &&
            state_reg.accum == 32'd0)
        else $error("parser state not cleared after end of string");

    // characters that make no result leave a stalled result word alone
    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready && step_fire && !res_valid |=>
            out_vld_reg && $stable(address_reg) && $stable(addr_valid_reg))
        else $error("stalled result word changed");
`endif

endmodule
